[design/wss_pkg.sv]
package wss_pkg;

   // default table depth and the matching width of the weight total
   localparam int DEPTH_DEF     = 64;
   localparam int ADDR_W_DEF    = 6;
   localparam int TOTAL_W_DEF   = 22;
   localparam int ENTRY_COUNT_W = 7;

   // item operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   typedef struct packed {
      logic        op;
      logic [5:0]  entry_index;
      logic [15:0] weight;
      logic [15:0] entry_id;
      logic [15:0] random_fraction;
      logic        new_subset;
   } req_type;

   typedef struct packed {
      logic [15:0] picked_id;
      logic [5:0]  picked_index;
      logic        empty_res;
   } rsp_type;

   // one table word
   typedef struct packed {
      logic [15:0] weight;
      logic [15:0] entry_id;
   } entry_type;

   // accumulator control
   typedef struct packed {
      logic clear;
      logic add;
   } acc_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MUL,
      ST_WALK,
      ST_DONE
   } state_type;

endpackage

[design/wss_table.sv]
module wss_table
   import wss_pkg::*;
#(
   parameter int DEPTH  = DEPTH_DEF,
   parameter int ADDR_W = ADDR_W_DEF
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/wss_accum.sv]
module wss_accum
   import wss_pkg::*;
#(
   parameter int SUM_W = TOTAL_W_DEF
) (
   input  logic             clock,
   input  acc_ctrl_type     ctrl,
   input  logic [15:0]      operand,
   input  logic [SUM_W-1:0] limit,
   output logic [SUM_W-1:0] sum,
   output logic             above
);

   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;
   logic [SUM_W-1:0] added;

   // one adder shared by the total pass and the walk, and one compare for the walk
   assign added = sum_ff + SUM_W'(operand);
   assign above = added > limit;

   always_comb begin
      if (ctrl.clear) begin
         sum_in = '0;
      end else if (ctrl.add) begin
         sum_in = added;
      end else begin
         sum_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign sum = sum_ff;

endmodule

[design/weighted_subset_sampler.sv]
// weighted sampling without replacement over a table of up to DEPTH entries.
// a load item (op = load) writes one entry's weight and id and gives no
// result. a draw item scales random_fraction (Q0.16) by the remaining total
// weight, walks the running sum over the entries that are not yet removed
// and returns the first one whose running sum passes that threshold, then
// removes it and subtracts its weight. a draw with new_subset set first
// restores every entry and re-sums the weights of the first entry_count
// entries. when no weight is left the draw returns empty_res with id and
// index zero. every draw gives exactly one result, shown for one cycle on
// rsp_item with rsp_valid high; the receiver cannot stall it, so it must take
// the result in that cycle. busy is high from the cycle after a draw is taken
// until the cycle its result appears. the scans cover entry_count entries,
// capped at DEPTH; the single table read port and the shared accumulator
// take one entry per cycle, and the walk stops early at the picked entry.
// entry_count may only be written while no draw is in progress.
module weighted_subset_sampler
   import wss_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_item,
   output logic                     rsp_valid,
   output rsp_type                  rsp_item,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [ENTRY_COUNT_W-1:0] csr_data
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int TOT_W  = 16 + $clog2(DEPTH);

   // sequencer and datapath registers
   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         addr_ff, addr_in;
   logic                     issue_q_ff, issue_q_in;
   logic [ADDR_W-1:0]        idx_q_ff, idx_q_in;
   logic [15:0]              frac_ff, frac_in;
   logic [TOT_W-1:0]         total_ff, total_in;
   logic [TOT_W-1:0]         thr_ff, thr_in;
   logic [DEPTH-1:0]         removed_ff, removed_in;
   logic                     any_live_ff, any_live_in;
   logic [ADDR_W-1:0]        pick_idx_ff, pick_idx_in;
   logic [15:0]              pick_w_ff, pick_w_in;
   logic [15:0]              pick_id_ff, pick_id_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;
   logic [ENTRY_COUNT_W-1:0] entry_count_ff, entry_count_in;

   logic [CNT_W-1:0]         cnt;
   logic                     issue;
   logic                     live;
   logic                     accept;
   logic [TOT_W+15:0]        product;

   // table and accumulator hookup
   logic                     wr_en;
   entry_type                wr_data;
   entry_type                rd_data;
   acc_ctrl_type             acc_ctrl;
   logic [TOT_W-1:0]         acc_sum;
   logic                     acc_above;

   wss_table #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_item.entry_index)),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (addr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   wss_accum #(
      .SUM_W (TOT_W)
   ) u_accum (
      .clock   (clock),
      .ctrl    (acc_ctrl),
      .operand (rd_data.weight),
      .limit   (thr_ff),
      .sum     (acc_sum),
      .above   (acc_above)
   );

   // entries in use, capped at the table depth
   assign cnt = (32'(entry_count_ff) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(entry_count_ff);

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   // no count write in the cycle an item is taken
   assign csr_ready = !busy && !start;

   // table write for load items, dropped beyond the depth
   assign wr_en            = accept && (req_item.op == OP_LOAD)
                             && (32'(req_item.entry_index) < DEPTH);
   assign wr_data.weight   = req_item.weight;
   assign wr_data.entry_id = req_item.entry_id;

   // threshold = floor(fraction * total / 2^16)
   assign product = {{TOT_W{1'b0}}, frac_ff} * {16'b0, total_ff};

   // a read is issued while the scan pointer is inside the used entries
   assign issue = ((state_ff == ST_SUM) || (state_ff == ST_WALK)) && (addr_ff < cnt);
   assign live  = issue_q_ff && !removed_ff[idx_q_ff];

   assign entry_count_in = (csr_valid && csr_ready) ? csr_data : entry_count_ff;

   always_comb begin
      state_in       = state_ff;
      addr_in        = addr_ff;
      issue_q_in     = issue;
      idx_q_in       = addr_ff[ADDR_W-1:0];
      frac_in        = frac_ff;
      total_in       = total_ff;
      thr_in         = thr_ff;
      removed_in     = removed_ff;
      any_live_in    = any_live_ff;
      pick_idx_in    = pick_idx_ff;
      pick_w_in      = pick_w_ff;
      pick_id_in     = pick_id_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      acc_ctrl.clear = 1'b0;
      acc_ctrl.add   = 1'b0;

      if (issue) begin
         addr_in = addr_ff + 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_item.op == OP_DRAW)) begin
               frac_in = req_item.random_fraction;
               if (req_item.new_subset) begin
                  // restore every entry, then re-sum the weights
                  removed_in     = '0;
                  acc_ctrl.clear = 1'b1;
                  addr_in        = '0;
                  state_in       = ST_SUM;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end

         ST_SUM: begin
            acc_ctrl.add = issue_q_ff;
            if (!issue && !issue_q_ff) begin
               total_in = acc_sum;
               state_in = ST_MUL;
            end
         end

         ST_MUL: begin
            if (total_ff == '0) begin
               rsp_valid_in     = 1'b1;
               rsp_in           = '0;
               rsp_in.empty_res = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               thr_in         = product[TOT_W+15:16];
               acc_ctrl.clear = 1'b1;
               addr_in        = '0;
               issue_q_in     = 1'b0;
               any_live_in    = 1'b0;
               state_in       = ST_WALK;
            end
         end

         ST_WALK: begin
            acc_ctrl.add = live;
            if (live) begin
               // last live entry so far, final pick once the sum passes
               any_live_in = 1'b1;
               pick_idx_in = idx_q_ff;
               pick_w_in   = rd_data.weight;
               pick_id_in  = rd_data.entry_id;
            end
            if (live && acc_above) begin
               issue_q_in = 1'b0;
               state_in   = ST_DONE;
            end else if (!issue && !issue_q_ff) begin
               if (any_live_ff) begin
                  // threshold past the live sum: clamp to last live entry
                  state_in = ST_DONE;
               end else begin
                  rsp_valid_in     = 1'b1;
                  rsp_in           = '0;
                  rsp_in.empty_res = 1'b1;
                  state_in         = ST_IDLE;
               end
            end
         end

         ST_DONE: begin
            removed_in[pick_idx_ff] = 1'b1;
            if (total_ff > TOT_W'(pick_w_ff)) begin
               total_in = total_ff - TOT_W'(pick_w_ff);
            end else begin
               total_in = '0;
            end
            rsp_valid_in        = 1'b1;
            rsp_in.picked_id    = pick_id_ff;
            rsp_in.picked_index = 6'(pick_idx_ff);
            rsp_in.empty_res    = 1'b0;
            state_in            = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_q_ff     <= 1'b0;
         total_ff       <= '0;
         removed_ff     <= '0;
         any_live_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         entry_count_ff <= '0;
      end else begin
         issue_q_ff     <= issue_q_in;
         total_ff       <= total_in;
         removed_ff     <= removed_in;
         any_live_ff    <= any_live_in;
         rsp_valid_ff   <= rsp_valid_in;
         entry_count_ff <= entry_count_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      idx_q_ff    <= idx_q_in;
      frac_ff     <= frac_in;
      thr_ff      <= thr_in;
      pick_idx_ff <= pick_idx_in;
      pick_w_ff   <= pick_w_in;
      pick_id_ff  <= pick_id_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   // a result strobe is never held high back to back
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // an empty result carries zero id and index
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.empty_res) |-> (rsp_item.picked_id == '0 &&
      rsp_item.picked_index == '0))
      else $error("empty result with nonzero payload");

   // every draw ends with exactly its result
   a_busy_ends_with_item: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("draw finished without a result");

   // a picked entry was live when picked
   a_pick_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> !removed_ff[pick_idx_ff])
      else $error("picked an entry that was already removed");

   // the total only grows through a re-sum
   a_total_no_growth: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) != ST_SUM && !$past(reset)) |-> (total_ff <= $past(total_ff)))
      else $error("remaining total grew outside a re-sum");
`endif

endmodule
